/* sv/pptbs_pkg.sv */
// Shared types and constants for the ping-pong tail block sequencer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package pptbs_pkg;

    // widths of block numbers and generations inside the block
    localparam int BLOCK_BITS = 64;
    localparam int GEN_BITS   = 32;

    // stream payload widths
    localparam int S_DATA_BITS = 328;
    localparam int M_DATA_BITS = 232;

    typedef logic [BLOCK_BITS-1:0] blk_t;
    typedef logic [GEN_BITS-1:0]   gen_t;

    // incoming command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_SYNC  = 2'd3
    } cmd_t;

    // device command / reply codes
    typedef enum logic [2:0] {
        OP_WRITE_IN   = 3'd0,
        OP_READ_HOLD  = 3'd1,
        OP_WRITE_HELD = 3'd2,
        OP_SYNC       = 3'd3,
        OP_SET_TAIL   = 3'd4,
        OP_READ_REPLY = 3'd5,
        OP_NEVER      = 3'd6,
        OP_FAILED     = 3'd7
    } op_t;

    // what the back end has to issue for one request
    typedef enum logic [3:0] {
        K_REWRITE   = 4'd0,
        K_NEW_PLAIN = 4'd1,
        K_NEW_SYNC  = 4'd2,
        K_NEW_ODD   = 4'd3,
        K_READ_OK   = 4'd4,
        K_READ_BAD  = 4'd5,
        K_SET_BAD   = 4'd6,
        K_SET_EVEN  = 4'd7,
        K_SET_ODD   = 4'd8,
        K_SYNC      = 4'd9
    } kind_t;

    // classified request handed from front to back
    typedef struct packed {
        kind_t       kind;
        blk_t        n;
        blk_t        tb;
        gen_t        g;
        logic [63:0] seq;
        logic        copy;
        op_t         bad_op;
    } job_t;

    // one device command
    typedef struct packed {
        op_t         op;
        blk_t        addr;
        blk_t        mblk;
        gen_t        mgen;
        logic [63:0] seq;
        logic        copy;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

/* sv/pptbs_front.sv */
// Front end: accepts requests, keeps the tail state and classifies each
// request into a job. Depends on pptbs_pkg.
`default_nettype none

module pptbs_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   q_full,
    input  wire logic [1:0]             cmd_in,
    input  wire logic [63:0]            block_number,
    input  wire logic [63:0]            seq_number,
    input  wire logic                   copy0_ok,
    input  wire logic [63:0]            copy0_tag,
    input  wire logic [31:0]            copy0_gen,
    input  wire logic                   copy1_ok,
    input  wire logic [63:0]            copy1_tag,
    input  wire logic [31:0]            copy1_gen,
    output logic                        in_ready,
    output logic                        push,
    output pptbs_pkg::job_t             job
);
    import pptbs_pkg::*;

    blk_t        tail_blk_reg, tail_blk_next;
    gen_t        tail_gen_reg, tail_gen_next;
    logic [63:0] tail_seq_reg, tail_seq_next;

    blk_t n;
    gen_t g0, g1, ng_tail;
    logic hit0, hit1, ch_ok, ch_copy;
    op_t  ch_bad;
    gen_t ch_gen, ng_ch;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign n       = block_number[BLOCK_BITS-1:0];
    assign g0      = copy0_gen[GEN_BITS-1:0];
    assign g1      = copy1_gen[GEN_BITS-1:0];
    assign hit0    = copy0_tag[BLOCK_BITS-1:0] == n;
    assign hit1    = copy1_tag[BLOCK_BITS-1:0] == n;
    assign ng_tail = tail_gen_reg + GEN_BITS'(1);
    assign ng_ch   = ch_gen + GEN_BITS'(1);

    // copy choice between the two presented stores
    always_comb
    begin
        ch_ok   = 1'b0;
        ch_copy = 1'b0;
        ch_gen  = g0;
        ch_bad  = OP_FAILED;
        if (copy0_ok)
        begin
            if (!hit0)
            begin
                ch_bad = OP_NEVER;
            end
            else if (copy1_ok && hit1 && (g0 <= g1))
            begin
                ch_ok   = 1'b1;
                ch_copy = 1'b1;
                ch_gen  = g1;
            end
            else
            begin
                ch_ok = 1'b1;
            end
        end
        else if (copy1_ok && hit1)
        begin
            ch_ok   = 1'b1;
            ch_copy = 1'b1;
            ch_gen  = g1;
        end
    end

    // classification and next tail state
    always_comb
    begin
        tail_blk_next = tail_blk_reg;
        tail_gen_next = tail_gen_reg;
        tail_seq_next = tail_seq_reg;
        job.kind   = K_SYNC;
        job.n      = n;
        job.tb     = tail_blk_reg;
        job.g      = tail_gen_reg;
        job.seq    = seq_number;
        job.copy   = ch_copy;
        job.bad_op = ch_bad;
        case (cmd_t'(cmd_in))
            CMD_WRITE:
            begin
                job.seq = tail_seq_reg;
                if (n == tail_blk_reg)
                begin
                    job.kind      = K_REWRITE;
                    job.g         = ng_tail;
                    tail_gen_next = ng_tail;
                end
                else
                begin
                    if (tail_gen_reg[0])
                        job.kind = K_NEW_ODD;
                    else if (tail_gen_reg != '0)
                        job.kind = K_NEW_SYNC;
                    else
                        job.kind = K_NEW_PLAIN;
                    tail_blk_next = n;
                    tail_gen_next = '0;
                end
            end
            CMD_READ:
            begin
                job.kind = ch_ok ? K_READ_OK : K_READ_BAD;
                job.g    = ch_gen;
            end
            CMD_SET:
            begin
                tail_seq_next = seq_number;
                if (!ch_ok)
                begin
                    job.kind      = K_SET_BAD;
                    tail_blk_next = '1;
                    tail_gen_next = '0;
                end
                else if (!ch_gen[0])
                begin
                    job.kind      = K_SET_EVEN;
                    tail_blk_next = n;
                    tail_gen_next = ch_gen;
                end
                else
                begin
                    job.kind      = K_SET_ODD;
                    job.g         = ng_ch;
                    tail_blk_next = n;
                    tail_gen_next = ng_ch;
                end
            end
            default:
            begin
                job.kind      = K_SYNC;
                tail_seq_next = seq_number;
            end
        endcase
    end

    // tail state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_blk_reg <= '1;
            tail_gen_reg <= '0;
            tail_seq_reg <= '0;
        end
        else if (push)
        begin
            tail_blk_reg <= tail_blk_next;
            tail_gen_reg <= tail_gen_next;
            tail_seq_reg <= tail_seq_next;
        end
    end

endmodule

`default_nettype wire

/* sv/pptbs_queue.sv */
// Two-entry job queue between front and back ends.
// Depends on pptbs_pkg for the job type.
`default_nettype none

module pptbs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pptbs_pkg::job_t push_job,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output pptbs_pkg::job_t      head
);
    import pptbs_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

/* sv/pptbs_back.sv */
// Back end: expands each queued job into its device commands, one per cycle
// while the output is not stalled, into an output register. Depends on pptbs_pkg.
`default_nettype none

module pptbs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire pptbs_pkg::job_t job,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pptbs_pkg::res_t      out_res
);
    import pptbs_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       valid_reg;
    res_t       res_reg;
    res_t       r;
    logic       emit;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign emit      = !q_empty && (!valid_reg || out_ready);
    assign pop       = emit && r.last;
    assign step_next = r.last ? 3'd0 : step_reg + 3'd1;

    // device command for the current job and step
    always_comb
    begin
        r = '0;
        case (job.kind)
            K_REWRITE:
            begin
                r.op   = OP_WRITE_IN;
                r.addr = job.n + BLOCK_BITS'(job.g[0]);
                r.mblk = job.n;
                r.mgen = job.g;
                r.last = 1'b1;
            end
            K_NEW_PLAIN:
            begin
                r.op   = OP_WRITE_IN;
                r.addr = job.n;
                r.mblk = job.n;
                r.last = 1'b1;
            end
            K_NEW_SYNC:
            begin
                if (step_reg == 3'd0)
                begin
                    r.op  = OP_SYNC;
                    r.seq = job.seq;
                end
                else
                begin
                    r.op   = OP_WRITE_IN;
                    r.addr = job.n;
                    r.mblk = job.n;
                    r.last = 1'b1;
                end
            end
            K_NEW_ODD:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        r.op   = OP_READ_HOLD;
                        r.addr = job.tb + BLOCK_BITS'(1);
                        r.mblk = job.tb;
                        r.mgen = job.g;
                        r.copy = 1'b1;
                    end
                    3'd1, 3'd3:
                    begin
                        r.op  = OP_SYNC;
                        r.seq = job.seq;
                    end
                    3'd2:
                    begin
                        r.op   = OP_WRITE_HELD;
                        r.addr = job.tb;
                        r.mblk = job.tb;
                        r.mgen = job.g + GEN_BITS'(1);
                        r.copy = 1'b1;
                    end
                    default:
                    begin
                        r.op   = OP_WRITE_IN;
                        r.addr = job.n;
                        r.mblk = job.n;
                        r.last = 1'b1;
                    end
                endcase
            end
            K_READ_OK:
            begin
                r.op   = OP_READ_REPLY;
                r.addr = job.n + BLOCK_BITS'(job.copy);
                r.mblk = job.n;
                r.mgen = job.g;
                r.copy = job.copy;
                r.last = 1'b1;
            end
            K_READ_BAD:
            begin
                r.op   = job.bad_op;
                r.addr = job.n;
                r.last = 1'b1;
            end
            K_SET_BAD:
            begin
                if (step_reg == 3'd0)
                begin
                    r.op   = job.bad_op;
                    r.addr = job.n;
                end
                else
                begin
                    r.op   = OP_SET_TAIL;
                    r.addr = job.n;
                    r.seq  = job.seq;
                    r.last = 1'b1;
                end
            end
            K_SET_EVEN:
            begin
                r.op   = OP_SET_TAIL;
                r.addr = job.n;
                r.seq  = job.seq;
                r.last = 1'b1;
            end
            K_SET_ODD:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        r.op   = OP_WRITE_HELD;
                        r.addr = job.n;
                        r.mblk = job.n;
                        r.mgen = job.g;
                        r.copy = job.copy;
                    end
                    3'd1:
                    begin
                        r.op  = OP_SYNC;
                        r.seq = job.seq;
                    end
                    default:
                    begin
                        r.op   = OP_SET_TAIL;
                        r.addr = job.n;
                        r.seq  = job.seq;
                        r.last = 1'b1;
                    end
                endcase
            end
            K_SYNC:
            begin
                r.op   = OP_SYNC;
                r.seq  = job.seq;
                r.last = 1'b1;
            end
            default:
            begin
                r.last = 1'b1;
            end
        endcase
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= r;
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                step_reg <= step_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sv/ping_pong_tail_block_sequencer.sv */
// Ping-pong log tail sequencer: turns write, read, set-tail and sync requests
// into device commands. Depends on pptbs_pkg, pptbs_front, pptbs_queue, pptbs_back.
`default_nettype none

// Each request on the s_ side yields one to five device commands on the m_
// side, in order, the final one marked by m_tlast. The back end issues one
// command per cycle unless the output is stalled by m_tready, and works on
// one request until all its commands are out (1 command for a rewrite, read
// or sync; up to 5 for a write that moves an odd-generation tail home). The
// front end accepts one request per cycle while its two-entry job queue has
// room, updating the tail block, generation and sequence number at acceptance.
// There is no startup sweep: a request can be taken as soon as reset is released.
module ping_pong_tail_block_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // block_number, seq_number, copy0_ok, copy0_tag, copy0_gen,
    // copy1_ok, copy1_tag, copy1_gen, zero pad
    input  wire logic [pptbs_pkg::S_DATA_BITS-1:0] s_tdata,
    // cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // store_address, meta_block, meta_gen, sync_seq, chosen_copy, zero pad
    output logic [pptbs_pkg::M_DATA_BITS-1:0] m_tdata,
    // op
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);
    import pptbs_pkg::*;

    logic q_full, q_empty, push, pop;
    job_t push_job, head_job;
    res_t res;

    pptbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .q_full       (q_full),
        .cmd_in       (s_tuser),
        .block_number (s_tdata[63:0]),
        .seq_number   (s_tdata[127:64]),
        .copy0_ok     (s_tdata[128]),
        .copy0_tag    (s_tdata[192:129]),
        .copy0_gen    (s_tdata[224:193]),
        .copy1_ok     (s_tdata[225]),
        .copy1_tag    (s_tdata[289:226]),
        .copy1_gen    (s_tdata[321:290]),
        .in_ready     (s_tready),
        .push         (push),
        .job          (push_job)
    );

    pptbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_job)
    );

    pptbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job       (head_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // result packing
    assign m_tuser          = res.op;
    assign m_tlast          = res.last;
    assign m_tdata[63:0]    = 64'(res.addr);
    assign m_tdata[127:64]  = 64'(res.mblk);
    assign m_tdata[159:128] = 32'(res.mgen);
    assign m_tdata[223:160] = res.seq;
    assign m_tdata[224]     = res.copy;
    assign m_tdata[231:225] = 7'd0;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for ping_pong_tail_block_sequencer: directed and random requests,
// predicted device commands checked in order. Depends on pptbs_pkg and the sequencer RTL.
`default_nettype none

module tb;

    import pptbs_pkg::*;

    // one request as the bench sees it
    typedef struct {
        cmd_t        cmd;
        blk_t        blk;
        logic [63:0] seq;
        logic        ok0;
        blk_t        tag0;
        gen_t        gen0;
        logic        ok1;
        blk_t        tag1;
        gen_t        gen1;
    } request_t;

    // tail state tracker and in-order command checker
    class tail_scoreboard;
        blk_t        tail_blk;
        gen_t        tail_gen;
        logic [63:0] tail_seq;
        res_t        cmds_due[$];
        int          errors;

        function new();
            tail_blk = '1;
            tail_gen = '0;
            tail_seq = '0;
            errors   = 0;
        endfunction

        function int pending();
            return cmds_due.size();
        endfunction

        function void push(op_t op, blk_t addr, blk_t mblk, gen_t mgen,
                           logic [63:0] seq, logic copy);
            res_t r;
            r.op   = op;
            r.addr = addr;
            r.mblk = mblk;
            r.mgen = mgen;
            r.seq  = seq;
            r.copy = copy;
            r.last = 1'b0;
            cmds_due.push_back(r);
        endfunction

        // pick between the two presented copies; reply, never written or failed
        function op_t pick_copy(request_t r, output logic copy, output gen_t gen);
            logic hit0;
            logic hit1;
            hit0 = (r.tag0 == r.blk);
            hit1 = (r.tag1 == r.blk);
            copy = 1'b0;
            gen  = '0;
            if (r.ok0)
            begin
                if (!hit0)
                    return OP_NEVER;
                if (r.ok1 && hit1 && !(r.gen0 > r.gen1))
                begin
                    copy = 1'b1;
                    gen  = r.gen1;
                end
                else
                    gen = r.gen0;
                return OP_READ_REPLY;
            end
            if (r.ok1 && hit1)
            begin
                copy = 1'b1;
                gen  = r.gen1;
                return OP_READ_REPLY;
            end
            return OP_FAILED;
        endfunction

        // work out the device commands of one accepted request
        function void note_request(request_t r);
            gen_t ng;
            gen_t gen;
            logic copy;
            op_t  outcome;
            case (r.cmd)
                CMD_WRITE:
                begin
                    if (r.blk == tail_blk)
                    begin
                        // rewrite alternates between n and n+1 by parity
                        ng = tail_gen + 1'b1;
                        push(OP_WRITE_IN, r.blk + ng[0], r.blk, ng, '0, 1'b0);
                        tail_gen = ng;
                    end
                    else
                    begin
                        // secure the old tail first
                        if (!tail_gen[0])
                        begin
                            if (tail_gen != '0)
                                push(OP_SYNC, '0, '0, '0, tail_seq, 1'b0);
                        end
                        else
                        begin
                            push(OP_READ_HOLD, tail_blk + 1'b1, tail_blk, tail_gen,
                                 '0, 1'b1);
                            push(OP_SYNC, '0, '0, '0, tail_seq, 1'b0);
                            push(OP_WRITE_HELD, tail_blk, tail_blk, tail_gen + 1'b1,
                                 '0, 1'b1);
                            push(OP_SYNC, '0, '0, '0, tail_seq, 1'b0);
                        end
                        push(OP_WRITE_IN, r.blk, r.blk, '0, '0, 1'b0);
                        tail_blk = r.blk;
                        tail_gen = '0;
                    end
                end
                CMD_READ:
                begin
                    outcome = pick_copy(r, copy, gen);
                    if (outcome == OP_READ_REPLY)
                        push(OP_READ_REPLY, r.blk + copy, r.blk, gen, '0, copy);
                    else
                        push(outcome, r.blk, '0, '0, '0, 1'b0);
                end
                CMD_SET:
                begin
                    outcome = pick_copy(r, copy, gen);
                    if (outcome != OP_READ_REPLY)
                    begin
                        push(outcome, r.blk, '0, '0, '0, 1'b0);
                        tail_blk = '1;
                        tail_gen = '0;
                    end
                    else if (!gen[0])
                    begin
                        tail_blk = r.blk;
                        tail_gen = gen;
                    end
                    else
                    begin
                        // odd copy gets moved home before the tail is set
                        ng = gen + 1'b1;
                        push(OP_WRITE_HELD, r.blk, r.blk, ng, '0, copy);
                        push(OP_SYNC, '0, '0, '0, r.seq, 1'b0);
                        tail_blk = r.blk;
                        tail_gen = ng;
                    end
                    push(OP_SET_TAIL, r.blk, '0, '0, r.seq, 1'b0);
                    tail_seq = r.seq;
                end
                default:
                begin
                    push(OP_SYNC, '0, '0, '0, r.seq, 1'b0);
                    tail_seq = r.seq;
                end
            endcase
            cmds_due[cmds_due.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one device command against the oldest one due
        function void check_command(res_t got);
            res_t want;
            if (cmds_due.size() == 0)
            begin
                $display("%0t: unexpected command, expected none, actual op %0d addr %h",
                         $time, got.op, got.addr);
                errors++;
                return;
            end
            want = cmds_due.pop_front();
            compare_field("op", want.op, got.op);
            compare_field("store_address", want.addr, got.addr);
            compare_field("meta_block", want.mblk, got.mblk);
            compare_field("meta_gen", want.mgen, got.mgen);
            compare_field("sync_seq", want.seq, got.seq);
            compare_field("chosen_copy", want.copy, got.copy);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // block_number, seq_number, copy0_ok, copy0_tag, copy0_gen,
    // copy1_ok, copy1_tag, copy1_gen, zero pad
    logic [327:0] s_tdata;
    // cmd
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // store_address, meta_block, meta_gen, sync_seq, chosen_copy, zero pad
    logic [231:0] m_tdata;
    // op
    logic [2:0]   m_tuser;
    logic         m_tlast;

    tail_scoreboard sb = new();
    int             send_idle;
    int             recv_idle;
    blk_t           hot_block;

    ping_pong_tail_block_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // watch both handshakes and drive the receiver's ready
    initial
    begin
        request_t req;
        res_t     cmd;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (s_tvalid && s_tready)
                begin
                    req.cmd  = cmd_t'(s_tuser);
                    req.blk  = s_tdata[63:0];
                    req.seq  = s_tdata[127:64];
                    req.ok0  = s_tdata[128];
                    req.tag0 = s_tdata[192:129];
                    req.gen0 = s_tdata[224:193];
                    req.ok1  = s_tdata[225];
                    req.tag1 = s_tdata[289:226];
                    req.gen1 = s_tdata[321:290];
                    sb.note_request(req);
                end
                if (m_tvalid && m_tready)
                begin
                    cmd.op   = op_t'(m_tuser);
                    cmd.addr = m_tdata[63:0];
                    cmd.mblk = m_tdata[127:64];
                    cmd.mgen = m_tdata[159:128];
                    cmd.seq  = m_tdata[223:160];
                    cmd.copy = m_tdata[224];
                    cmd.last = m_tlast;
                    sb.check_command(cmd);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic request_t make_req(cmd_t cmd, blk_t blk, logic [63:0] seq,
                                          logic ok0, blk_t tag0, gen_t gen0,
                                          logic ok1, blk_t tag1, gen_t gen1);
        request_t r;
        r.cmd  = cmd;
        r.blk  = blk;
        r.seq  = seq;
        r.ok0  = ok0;
        r.tag0 = tag0;
        r.gen0 = gen0;
        r.ok1  = ok1;
        r.tag1 = tag1;
        r.gen1 = gen1;
        return r;
    endfunction

    // generations cluster at small values and near the wrap
    function automatic gen_t rand_gen();
        case ($urandom_range(3))
            0, 1:    return gen_t'($urandom_range(5));
            2:       return gen_t'($urandom);
            default: return 32'hFFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    // mostly well-formed traffic around the current tail, some noise
    function automatic request_t make_random_request();
        request_t r;
        int       pick;
        blk_t     top;
        top  = '1;
        pick = $urandom_range(99);
        if (pick < 40)
            r.cmd = CMD_WRITE;
        else if (pick < 65)
            r.cmd = CMD_READ;
        else if (pick < 85)
            r.cmd = CMD_SET;
        else
            r.cmd = CMD_SYNC;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: r.blk = hot_block;
            5, 6:          r.blk = blk_t'($urandom_range(7));
            7:             r.blk = top - $urandom_range(1);
            default:       r.blk = {$urandom, $urandom};
        endcase
        r.seq  = {$urandom, $urandom};
        r.ok0  = ($urandom_range(3) != 0);
        r.ok1  = ($urandom_range(3) != 0);
        r.tag0 = ($urandom_range(9) < 7) ? r.blk : blk_t'({$urandom, $urandom});
        r.tag1 = ($urandom_range(9) < 7) ? r.blk : blk_t'({$urandom, $urandom});
        r.gen0 = rand_gen();
        r.gen1 = rand_gen();
        if (r.cmd == CMD_WRITE || r.cmd == CMD_SET)
            hot_block = r.blk;
        return r;
    endfunction

    // present one request and hold it until taken
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {6'b0, r.gen1, r.tag1, r.ok1, r.gen0, r.tag0, r.ok0, r.seq, r.blk};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending until every due command has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic random_phase(int snd, int rcv, int count);
        send_idle = snd;
        recv_idle = rcv;
        repeat (count)
            send_request(make_random_request());
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        blk_t        ones;
        logic [63:0] seq_max;
        ones      = '1;
        seq_max   = '1;
        hot_block = '0;
        send_idle = 11;
        recv_idle = 59;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_WRITE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write sequences: new tail, rewrites, even and odd tail handover
        send_request(make_req(CMD_WRITE, 5, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 5, 0, 1, 5, 9, 1, 5, 9));
        send_request(make_req(CMD_WRITE, 5, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 9, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 9, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 20, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_SYNC, 0, seq_max, 0, 0, 0, 0, 0, 0));
        // copy choice on reads
        send_request(make_req(CMD_READ, 20, 0, 1, 20, 3, 1, 20, 7));
        send_request(make_req(CMD_READ, 20, 0, 1, 20, 7, 1, 20, 3));
        send_request(make_req(CMD_READ, 20, 0, 1, 20, 4, 1, 20, 4));
        send_request(make_req(CMD_READ, 20, 0, 1, 21, 4, 1, 20, 4));
        send_request(make_req(CMD_READ, 20, 0, 0, 20, 2, 1, 20, 4));
        send_request(make_req(CMD_READ, 20, 0, 0, 20, 2, 0, 20, 4));
        send_request(make_req(CMD_READ, 20, 0, 0, 20, 2, 1, 22, 4));
        // set tail: odd copy, even copy, unreadable copy
        send_request(make_req(CMD_SET, 30, 123, 1, 30, 5, 0, 30, 9));
        send_request(make_req(CMD_SET, 30, 0, 1, 30, 8, 0, 0, 0));
        send_request(make_req(CMD_SET, 30, 77, 1, 31, 8, 1, 30, 8));
        // all-ones block counts as the tail when there is none; addresses wrap
        send_request(make_req(CMD_WRITE, ones, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
        // generation wrap on set tail and on rewrites
        send_request(make_req(CMD_SET, ones, seq_max, 1, ones, 32'hFFFF_FFFF,
                              0, ones, 32'hFFFF_FFFF));
        send_request(make_req(CMD_SET, 40, 1, 1, 40, 32'hFFFF_FFFE, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 40, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_WRITE, 40, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_SET, 40, 2, 0, 40, 2, 0, 40, 2));
        send_request(make_req(CMD_READ, ones, 0, 0, ones, 0, 1, ones, 32'hFFFF_FFFF));
        wait_drained();

        // random traffic under three idling patterns
        random_phase(11, 59, 120);
        random_phase(59, 11, 120);
        random_phase(0, 0, 120);

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
